[sv/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the block buffer cache slot manager: the
// request and response payloads, the per-slot record held in memory and the
// controller state encoding.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Default number of cache slots.
    localparam int SLOT_COUNT_DEF = 8;

    // Fixed field widths.
    localparam int TAG_W        = 16;
    localparam int CNT_W        = 8;
    localparam int SLOT_FIELD_W = 3;

    // Saturation limit of a reference count.
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Opcodes.
    localparam logic OP_READ    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic                    opcode;
        logic [TAG_W-1:0]        block_number;
        logic [SLOT_FIELD_W-1:0] slot_index;
    } t_req;

    // Output transaction payload.
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    hit;
        logic                    fill_needed;
        logic                    no_free_slot;
    } t_rsp;

    // Result handed from the controller to the output stage.
    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_res;

    // Per-slot record kept in the slot memory.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             data_valid;
        logic [CNT_W-1:0] ref_count;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_REL_RD,
        ST_DONE
    } t_state;

endpackage

[sv/bbc_ram.sv]
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bbc_slot_ctrl.sv]
// ----------------------------------------------------------------------------
// bbc_slot_ctrl
// Sequencer for the slot manager. A read sweeps the slot memory one entry
// per cycle, finding the first slot tagged with the block and the first
// unreferenced slot, then writes back the chosen record. A release reads
// one record and writes back the lowered count.
// ----------------------------------------------------------------------------
module bbc_slot_ctrl #(
    parameter int SLOT_COUNT = bbc_pkg::SLOT_COUNT_DEF,
    parameter int SW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request side.
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  bbc_pkg::t_req        i_req,
    // Slot memory port.
    output logic                 o_ram_we,
    output logic [SW-1:0]        o_ram_waddr,
    output logic [bbc_pkg::REC_W-1:0] o_ram_wdata,
    output logic [SW-1:0]        o_ram_raddr,
    input  logic [bbc_pkg::REC_W-1:0] i_ram_rdata,
    // Result side.
    output bbc_pkg::t_res        o_res,
    input  logic                 i_res_take
);

    import bbc_pkg::*;

    localparam logic [SW:0] LAST_ISSUE = (SW+1)'(SLOT_COUNT);

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [SW:0]      r_issue, n_issue;
    logic             r_chk_v, n_chk_v;
    logic [SW-1:0]    r_chk_idx, n_chk_idx;
    logic             r_found_m, n_found_m;
    logic [SW-1:0]    r_m_idx, n_m_idx;
    logic [CNT_W-1:0] r_m_cnt, n_m_cnt;
    logic             r_m_dv, n_m_dv;
    logic             r_found_f, n_found_f;
    logic [SW-1:0]    r_f_idx, n_f_idx;
    logic [SLOT_COUNT-1:0] r_assigned, n_assigned;
    t_rsp             r_rsp, n_rsp;

    t_rec             rd_rec;
    t_rec             wr_rec;
    logic             rd_assigned;
    logic [CNT_W-1:0] rd_cnt;

    // Decode the record returned by the memory; an unassigned slot reads as
    // empty whatever the memory holds.
    always_comb begin
        rd_rec      = t_rec'(i_ram_rdata);
        rd_assigned = r_assigned[r_chk_idx];
        rd_cnt      = rd_assigned ? rd_rec.ref_count : '0;
    end

    // Next state, memory access and result.
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_issue    = r_issue;
        n_chk_v    = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_found_m  = r_found_m;
        n_m_idx    = r_m_idx;
        n_m_cnt    = r_m_cnt;
        n_m_dv     = r_m_dv;
        n_found_f  = r_found_f;
        n_f_idx    = r_f_idx;
        n_assigned = r_assigned;
        n_rsp      = r_rsp;
        o_req_ready = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_chk_idx;
        o_ram_raddr = r_issue[SW-1:0];
        wr_rec      = rd_rec;

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_ram_raddr = SW'(i_req.slot_index);
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_issue   = '0;
                    n_found_m = 1'b0;
                    n_found_f = 1'b0;
                    n_rsp     = '0;
                    n_chk_idx = SW'(i_req.slot_index);
                    if (i_req.opcode == OP_RELEASE) begin
                        // Release of a slot past the end is dropped.
                        if (32'(i_req.slot_index) < SLOT_COUNT) begin
                            n_state = ST_REL_RD;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue the next read while checking the previous one.
                if (r_issue != LAST_ISSUE) begin
                    n_issue   = r_issue + 1'b1;
                    n_chk_v   = 1'b1;
                    n_chk_idx = r_issue[SW-1:0];
                end
                if (r_chk_v) begin
                    if (!r_found_m && rd_assigned && rd_rec.tag == r_req.block_number) begin
                        n_found_m = 1'b1;
                        n_m_idx   = r_chk_idx;
                        n_m_cnt   = rd_rec.ref_count;
                        n_m_dv    = rd_rec.data_valid;
                    end
                    if (!r_found_f && rd_cnt == '0) begin
                        n_found_f = 1'b1;
                        n_f_idx   = r_chk_idx;
                    end
                end
                if (r_issue == LAST_ISSUE && !r_chk_v) begin
                    n_state = ST_COMMIT;
                end
            end

            ST_COMMIT: begin
                n_state = ST_DONE;
                if (r_found_m) begin
                    // Hit: raise the count and mark the data present.
                    o_ram_we          = 1'b1;
                    o_ram_waddr       = r_m_idx;
                    wr_rec.tag        = r_req.block_number;
                    wr_rec.data_valid = 1'b1;
                    wr_rec.ref_count  = (r_m_cnt == COUNT_MAX) ? r_m_cnt
                                                               : r_m_cnt + 1'b1;
                    n_rsp.slot        = SLOT_FIELD_W'(r_m_idx);
                    n_rsp.hit         = 1'b1;
                    n_rsp.fill_needed = !r_m_dv;
                end else if (r_found_f) begin
                    // Miss: claim the first unreferenced slot.
                    o_ram_we              = 1'b1;
                    o_ram_waddr           = r_f_idx;
                    wr_rec.tag            = r_req.block_number;
                    wr_rec.data_valid     = 1'b1;
                    wr_rec.ref_count      = CNT_W'(1);
                    n_assigned[r_f_idx]   = 1'b1;
                    n_rsp.slot            = SLOT_FIELD_W'(r_f_idx);
                    n_rsp.fill_needed     = 1'b1;
                end else begin
                    n_rsp.no_free_slot = 1'b1;
                end
            end

            ST_REL_RD: begin
                // Read data for the released slot is here; lower its count.
                n_state = ST_DONE;
                if (rd_cnt != '0) begin
                    o_ram_we         = 1'b1;
                    o_ram_waddr      = r_chk_idx;
                    wr_rec.ref_count = rd_cnt - 1'b1;
                end
            end

            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ram_wdata = REC_W'(wr_rec);
    assign o_res.valid = (r_state == ST_DONE);
    assign o_res.rsp   = r_rsp;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_issue    <= '0;
            r_chk_v    <= 1'b0;
            r_found_m  <= 1'b0;
            r_found_f  <= 1'b0;
            r_assigned <= '0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_chk_v    <= n_chk_v;
            r_found_m  <= n_found_m;
            r_found_f  <= n_found_f;
            r_assigned <= n_assigned;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_chk_idx <= n_chk_idx;
        r_m_idx   <= n_m_idx;
        r_m_cnt   <= n_m_cnt;
        r_m_dv    <= n_m_dv;
        r_f_idx   <= n_f_idx;
        r_rsp     <= n_rsp;
    end

`ifndef SYNTHESIS
    // Memory writes happen only at the end of a transaction's work.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == ST_COMMIT || r_state == ST_REL_RD))
        else $error("slot memory written outside commit");

    // The sweep pointer never runs past SLOT_COUNT, one beyond the last slot.
    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= LAST_ISSUE)
        else $error("sweep pointer out of range");

    // A full cache reports neither hit nor fill.
    a_nofree_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.rsp.no_free_slot) |->
            (!o_res.rsp.hit && !o_res.rsp.fill_needed))
        else $error("no free slot combined with hit or fill");

    // A claimed slot is marked assigned from the next cycle on.
    a_claim_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && !r_found_m && r_found_f) |=>
            r_assigned[$past(r_f_idx)])
        else $error("claimed slot not marked assigned");

    // A new transaction is taken only after the previous result left.
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_res_take) |=> (r_state == ST_DONE))
        else $error("result dropped before it was taken");
`endif

endmodule

[sv/block_buffer_cache_slot_manager_unit.sv]
// ----------------------------------------------------------------------------
// block_buffer_cache_slot_manager_unit
// Tag and reference-count manager for a small fully associative disk block
// cache.
//
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_ready /
//   i_in_data). A read looks up a block number, raises the count of the
//   matching slot or claims the first unreferenced one; a release lowers the
//   count of a slot. Every request yields one response on the output channel
//   (o_out_valid / i_out_ready / o_out_data).
//   Per-slot records (tag, data-valid flag, count) live in one synchronous
//   memory with one read and one write port. A read sweeps it one slot per
//   cycle; a release reads and writes back only its own slot. One request
//   is worked on at a time, so a new request is not taken while a read or
//   a release is still in progress.
//   Reset clears the tag-assigned flags, which makes every slot read as
//   empty; there is no clearing pass and the block is ready the cycle after
//   reset. A response waits in the output register while the receiver
//   stalls; the next request is accepted once the prior result has moved
//   into that register, and it stalls at its end until the register frees.
// ----------------------------------------------------------------------------
module block_buffer_cache_slot_manager_unit #(
    parameter int SLOT_COUNT = bbc_pkg::SLOT_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bbc_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bbc_pkg::t_rsp o_out_data
);

    import bbc_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic [SW-1:0]    ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    t_res             res;
    logic             res_take;
    logic             r_out_valid;
    t_rsp             r_out;

    // Slot record memory.
    bbc_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOT_COUNT),
        .AW    (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Lookup and count sequencer.
    bbc_slot_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // Output register: takes a result when empty or being drained.
    assign res_take = res.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res.rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[test/tb_block_buffer_cache_slot_manager_unit.sv]
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_slot_manager_unit
// Self-checking testbench for the block buffer cache slot manager. A local
// model of the slot tags, valid flags and reference counts predicts every
// response. Directed tests cover the corner cases, then random traffic runs
// under several sender and receiver idling mixes, with a long receiver
// hold-off and a full drain in between.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_slot_manager_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int SLOTS      = SLOT_COUNT_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = SLOTS + 8;
    localparam int MAX_SHOWN  = 10;

    // Clock, reset and block ports.
    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic o_in_ready;
    t_req in_data   = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    t_rsp o_out_data;

    // Idling controls shared by the sender, the receiver and the tests.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    // Local copy of the cache bookkeeping.
    logic [TAG_W-1:0] slot_tag     [SLOTS];
    logic             slot_assigned[SLOTS];
    logic             slot_valid   [SLOTS];
    logic [CNT_W-1:0] slot_refs    [SLOTS];

    // Responses still owed by the block, oldest first.
    t_rsp pending_rsp[$];
    int   fail_count = 0;
    int   idle_cycles = 0;

    block_buffer_cache_slot_manager_unit #(
        .SLOT_COUNT(SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the local model and return the response it owes.
    function automatic t_rsp cache_predict(t_req req);
        t_rsp rsp;
        int   found;
        rsp   = '0;
        found = -1;
        if (req.opcode == OP_RELEASE) begin
            if (req.slot_index < SLOTS && slot_refs[req.slot_index] != '0) begin
                slot_refs[req.slot_index] = slot_refs[req.slot_index] - 1'b1;
            end
            return rsp;
        end
        // Look for a slot already tagged with this block.
        for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && slot_assigned[i] && slot_tag[i] == req.block_number) begin
                found = i;
            end
        end
        if (found >= 0) begin
            rsp.hit = 1'b1;
            if (slot_refs[found] != COUNT_MAX) begin
                slot_refs[found] = slot_refs[found] + 1'b1;
            end
        end else begin
            // Claim the lowest unreferenced slot.
            for (int i = 0; i < SLOTS; i++) begin
                if (found < 0 && slot_refs[i] == '0) begin
                    found = i;
                end
            end
            if (found < 0) begin
                rsp.no_free_slot = 1'b1;
                return rsp;
            end
            slot_tag[found]      = req.block_number;
            slot_assigned[found] = 1'b1;
            slot_valid[found]    = 1'b0;
            slot_refs[found]     = CNT_W'(1);
        end
        rsp.slot          = found[SLOT_FIELD_W-1:0];
        rsp.fill_needed   = ~slot_valid[found];
        slot_valid[found] = 1'b1;
        return rsp;
    endfunction

    // Offer one request; entered and left at a falling edge.
    task automatic send_req(input t_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_rsp.push_back(cache_predict(req));
        @(negedge i_clk);
    endtask

    task automatic send_read(input logic [TAG_W-1:0] blk);
        t_req req;
        req.opcode       = OP_READ;
        req.block_number = blk;
        req.slot_index   = SLOT_FIELD_W'($urandom_range(SLOTS - 1));
        send_req(req);
    endtask

    task automatic send_release(input int idx);
        t_req req;
        req.opcode       = OP_RELEASE;
        req.block_number = TAG_W'($urandom_range(16'hFFFF));
        req.slot_index   = SLOT_FIELD_W'(idx);
        send_req(req);
    endtask

    // Hold the input quiet until every owed response has come back.
    task automatic wait_for_responses();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    // Corner cases: empty cache, extreme block numbers, full cache, reuse.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Block 0 right after reset must miss, since no tag is assigned yet.
        send_read(16'h0000);
        send_read(16'hFFFF);
        send_read(16'h0000);
        // A release of a slot with no references leaves its count at zero.
        send_release(7);
        send_release(0);
        send_read(16'h5555);
        send_read(16'hAAAA);
        send_read(16'h8001);
        send_read(16'h7FFE);
        send_read(16'h00FF);
        send_read(16'hFF00);
        send_read(16'hFFFF);
        // Every slot referenced: the next miss finds nothing free.
        send_read(16'h8000);
        send_release(3);
        send_read(16'h8000);
        send_read(16'h8001);
        send_read(16'h8000);
        send_release(3);
        send_release(3);
        send_read(16'h8001);
        wait_for_responses();
    endtask

    // Drive one count to its ceiling and back past zero.
    task automatic test_count_saturation();
        logic [TAG_W-1:0] blk;
        blk = slot_tag[0];
        for (int i = 0; i < 258; i++) send_read(blk);
        for (int i = 0; i < 260; i++) send_release(0);
        wait_for_responses();
    endtask

    // Random traffic, mostly over a small working set of blocks.
    task automatic test_random(input int count, input int send_pct, input int recv_pct,
                               input int release_pct);
        logic [TAG_W-1:0] block_pool[16];
        block_pool[0] = 16'h0000;
        block_pool[1] = 16'hFFFF;
        for (int i = 2; i < 16; i++) block_pool[i] = TAG_W'($urandom_range(16'hFFFF));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < release_pct) begin
                send_release($urandom_range(SLOTS - 1));
            end else if ($urandom_range(99) < 80) begin
                send_read(block_pool[$urandom_range(15)]);
            end else begin
                send_read(TAG_W'($urandom_range(16'hFFFF)));
            end
        end
        wait_for_responses();
    endtask

    // The receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        for (int n = 0; n < 8; n++) begin
            if (n % 3 == 2) send_release($urandom_range(SLOTS - 1));
            else            send_read(TAG_W'($urandom_range(16'hFFFF)));
        end
        wait_for_responses();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each response transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_rsp.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("unexpected response %p", o_out_data);
                end
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.slot !== want.slot || o_out_data.hit !== want.hit ||
                    o_out_data.fill_needed !== want.fill_needed ||
                    o_out_data.no_free_slot !== want.no_free_slot) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN) begin
                        $display("mismatch: expected slot=%0d hit=%b fill=%b nofree=%b,",
                                 want.slot, want.hit, want.fill_needed, want.no_free_slot,
                                 " got slot=%0d hit=%b fill=%b nofree=%b",
                                 o_out_data.slot, o_out_data.hit, o_out_data.fill_needed,
                                 o_out_data.no_free_slot);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_tag[i]      = '0;
            slot_assigned[i] = 1'b0;
            slot_valid[i]    = 1'b0;
            slot_refs[i]     = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_count_saturation();
        test_random(75, 0, 0, 40);
        test_backpressure();
        test_random(76, 55, 0, 30);
        test_random(75, 0, 55, 55);
        test_random(76, 10, 10, 40);

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (pending_rsp.size() != 0) begin
            $display("%0d responses never arrived", pending_rsp.size());
            fail_count += pending_rsp.size();
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_slot_ctrl.sv
sv/block_buffer_cache_slot_manager_unit.sv
test/tb_block_buffer_cache_slot_manager_unit.sv
